FILE: src/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg: shared types and constants of the complex arithmetic unit
// Opcodes, request and response payloads, and the records that pass
// between the front pipeline, the divider array and the output stage.
// ---------------------------------------------------------------------------
package cau_pkg;

   // Width of every operand and result part (signed fixed point)
   localparam int DATA_WIDTH = 32;
   // Magnitude of any dividend, for every fraction width below DATA_WIDTH
   localparam int MAG_WIDTH  = 3 * DATA_WIDTH + 2;
   // Divisor width: sum of two squares of (DATA_WIDTH+1)-bit values
   localparam int DEN_WIDTH  = 2 * DATA_WIDTH + 2;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_PAR    = 4'd4,
      OP_SCALE  = 4'd5,
      OP_DIVR   = 4'd6,
      OP_NEG    = 4'd7,
      OP_RECIP  = 4'd8,
      OP_SQUARE = 4'd9
   } op_type;

   typedef struct packed {
      logic [3:0]                    opcode;
      logic signed [DATA_WIDTH-1:0]  a_real;
      logic signed [DATA_WIDTH-1:0]  a_imag;
      logic signed [DATA_WIDTH-1:0]  b_real;
      logic signed [DATA_WIDTH-1:0]  b_imag;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  y_real;
      logic signed [DATA_WIDTH-1:0]  y_imag;
      logic                          divide_by_zero;
      logic                          overflowed;
   } rsp_type;

   // Front pipeline result: dividends in sign-magnitude form plus the
   // finished result of the non-dividing operations
   typedef struct packed {
      logic                          is_div;
      logic                          dz;
      logic                          neg_r;
      logic                          neg_i;
      logic [MAG_WIDTH-1:0]          mag_r;
      logic [MAG_WIDTH-1:0]          mag_i;
      logic [DEN_WIDTH-1:0]          den;
      logic signed [DATA_WIDTH-1:0]  y_real;
      logic signed [DATA_WIDTH-1:0]  y_imag;
      logic                          ov;
   } fe_type;

   // One divider stage: partial remainder and shared dividend/quotient word
   typedef struct packed {
      logic                          is_div;
      logic                          dz;
      logic                          neg_r;
      logic                          neg_i;
      logic                          big_r;
      logic                          big_i;
      logic [DEN_WIDTH-1:0]          rem_r;
      logic [DEN_WIDTH-1:0]          rem_i;
      logic [DEN_WIDTH-1:0]          den;
      logic [DATA_WIDTH-1:0]         lq_r;
      logic [DATA_WIDTH-1:0]         lq_i;
      logic signed [DATA_WIDTH-1:0]  y_real;
      logic signed [DATA_WIDTH-1:0]  y_imag;
      logic                          ov;
   } dv_type;

endpackage

FILE: src/cau_front.sv
// ---------------------------------------------------------------------------
// cau_front: six-stage operand pipeline
// Sums, products, cross products and dividends; finishes the operations
// that need no division and hands dividends and divisor to the divider.
// ---------------------------------------------------------------------------
module cau_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cau_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cau_pkg::fe_type  out_data
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int XW = 2 * W + 2;
   localparam int NW = MAG_WIDTH + 1;
   localparam int DW = DEN_WIDTH;
   localparam logic [XW-1:0] RND = XW'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic signed [XW-1:0] MAXV = $signed(XW'((64'd1 << (W - 1)) - 64'd1));
   localparam logic signed [XW-1:0] MINV = -MAXV - $signed(XW'(1));

   // Shift right by the fraction width, truncating toward zero
   function automatic logic signed [XW-1:0] shr_tz(input logic signed [XW-1:0] x);
      logic signed [XW-1:0] t;
      t = x;
      if (x[XW-1]) t = x + $signed(RND);
      return t >>> FRAC_BITS;
   endfunction

   // Saturate to the result range; top bit reports saturation
   function automatic logic [W:0] sat(input logic signed [XW-1:0] x);
      logic [W:0] r;
      if (x > MAXV) r = {1'b1, MAXV[W-1:0]};
      else if (x < MINV) r = {1'b1, MINV[W-1:0]};
      else r = {1'b0, x[W-1:0]};
      return r;
   endfunction

   // Rebuild a value from its high and low partial products
   function automatic logic signed [NW-1:0] join_pp(input logic signed [XW-1:0] h,
                                                    input logic signed [XW-1:0] l);
      logic signed [NW-1:0] a;
      logic signed [NW-1:0] b;
      a = NW'(h);
      b = NW'(l);
      return (a <<< W) + b;
   endfunction

   logic [5:0] v_ff;
   logic       en;

   // Advance the whole pipeline unless the last stage holds a stalled request
   assign en        = !v_ff[5] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   // Stage 1: register operands, form a+b
   op_type               op1_ff;
   logic signed [W-1:0]  ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [W:0]    sr1_ff, si1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= op_type'(in_data.opcode);
         ar1_ff <= in_data.a_real;
         ai1_ff <= in_data.a_imag;
         br1_ff <= in_data.b_real;
         bi1_ff <= in_data.b_imag;
         sr1_ff <= (W+1)'(in_data.a_real) + (W+1)'(in_data.b_real);
         si1_ff <= (W+1)'(in_data.a_imag) + (W+1)'(in_data.b_imag);
      end
   end

   // Stage 2: six products
   op_type                 op2_ff;
   logic signed [W-1:0]    ar2_ff, ai2_ff, br2_ff, bi2_ff;
   logic signed [W:0]      sr2_ff, si2_ff;
   logic signed [2*W-1:0]  prr2_ff, pii2_ff, pri2_ff, pir2_ff;
   logic signed [XW-1:0]   qu2_ff, qv2_ff;
   logic signed [W-1:0]    bxr2_in, bxi2_in;
   logic signed [W:0]      u2_in, v2_in;

   always_comb begin
      bxr2_in = (op1_ff == OP_SQUARE) ? ar1_ff : br1_ff;
      bxi2_in = (op1_ff == OP_SQUARE) ? ai1_ff : bi1_ff;
      case (op1_ff)
         OP_PAR: begin
            u2_in = sr1_ff;
            v2_in = si1_ff;
         end
         OP_RECIP: begin
            u2_in = (W+1)'(ar1_ff);
            v2_in = (W+1)'(ai1_ff);
         end
         default: begin
            u2_in = (W+1)'(br1_ff);
            v2_in = (W+1)'(bi1_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op2_ff  <= op1_ff;
         ar2_ff  <= ar1_ff;
         ai2_ff  <= ai1_ff;
         br2_ff  <= br1_ff;
         bi2_ff  <= bi1_ff;
         sr2_ff  <= sr1_ff;
         si2_ff  <= si1_ff;
         prr2_ff <= ar1_ff * bxr2_in;
         pii2_ff <= ai1_ff * bxi2_in;
         pri2_ff <= ar1_ff * bxi2_in;
         pir2_ff <= ai1_ff * bxr2_in;
         qu2_ff  <= u2_in * u2_in;
         qv2_ff  <= v2_in * v2_in;
      end
   end

   // Stage 3: combine products into complex product, conjugate product, divisor
   op_type                 op3_ff;
   logic signed [W-1:0]    ar3_ff, ai3_ff, br3_ff, bi3_ff;
   logic signed [W:0]      sr3_ff, si3_ff;
   logic signed [2*W-1:0]  prr3_ff, pir3_ff;
   logic signed [2*W:0]    pr3_ff, pi3_ff, nr3_ff, ni3_ff;
   logic [DW-1:0]          den3_ff;
   logic signed [XW:0]     den3_in;

   assign den3_in = (XW+1)'(qu2_ff) + (XW+1)'(qv2_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         op3_ff  <= op2_ff;
         ar3_ff  <= ar2_ff;
         ai3_ff  <= ai2_ff;
         br3_ff  <= br2_ff;
         bi3_ff  <= bi2_ff;
         sr3_ff  <= sr2_ff;
         si3_ff  <= si2_ff;
         prr3_ff <= prr2_ff;
         pir3_ff <= pir2_ff;
         pr3_ff  <= (2*W+1)'(prr2_ff) - (2*W+1)'(pii2_ff);
         pi3_ff  <= (2*W+1)'(pri2_ff) + (2*W+1)'(pir2_ff);
         nr3_ff  <= (2*W+1)'(prr2_ff) + (2*W+1)'(pii2_ff);
         ni3_ff  <= (2*W+1)'(pir2_ff) - (2*W+1)'(pri2_ff);
         den3_ff <= den3_in[DW-1:0];
      end
   end

   // Stage 4: finish the non-dividing operations, partial products, dividends
   op_type                 op4_ff;
   logic signed [W-1:0]    br4_ff, yr4_ff, yi4_ff;
   logic                   ov4_ff;
   logic [DW-1:0]          den4_ff;
   logic signed [XW-1:0]   hprsr4_ff, lprsr4_ff, hpisi4_ff, lpisi4_ff;
   logic signed [XW-1:0]   hpisr4_ff, lpisr4_ff, hprsi4_ff, lprsi4_ff;
   logic signed [NW-1:0]   nsr4_ff, nsi4_ff;
   logic signed [XW-1:0]   xr4_in, xi4_in;
   logic [W:0]             sr4_in, si4_in;
   logic signed [NW-1:0]   nsr4_in, nsi4_in;
   logic signed [W:0]      prh4_in, prl4_in, pih4_in, pil4_in;

   always_comb begin
      xr4_in = '0;
      xi4_in = '0;
      case (op3_ff) inside
         OP_ADD: begin
            xr4_in = XW'(sr3_ff);
            xi4_in = XW'(si3_ff);
         end
         OP_SUB: begin
            xr4_in = XW'(ar3_ff) - XW'(br3_ff);
            xi4_in = XW'(ai3_ff) - XW'(bi3_ff);
         end
         OP_NEG: begin
            xr4_in = XW'(ar3_ff);
            xi4_in = XW'(ai3_ff);
            xr4_in = -xr4_in;
            xi4_in = -xi4_in;
         end
         OP_SCALE: begin
            xr4_in = shr_tz(XW'(prr3_ff));
            xi4_in = shr_tz(XW'(pir3_ff));
         end
         OP_MUL, OP_SQUARE: begin
            xr4_in = shr_tz(XW'(pr3_ff));
            xi4_in = shr_tz(XW'(pi3_ff));
         end
         default: begin
         end
      endcase
      sr4_in = sat(xr4_in);
      si4_in = sat(xi4_in);

      nsr4_in = '0;
      nsi4_in = '0;
      case (op3_ff)
         OP_DIV: begin
            nsr4_in = NW'(nr3_ff);
            nsi4_in = NW'(ni3_ff);
            nsr4_in = nsr4_in <<< FRAC_BITS;
            nsi4_in = nsi4_in <<< FRAC_BITS;
         end
         OP_RECIP: begin
            nsr4_in = NW'(ar3_ff);
            nsi4_in = NW'(ai3_ff);
            nsi4_in = -nsi4_in;
            nsr4_in = nsr4_in <<< (2 * FRAC_BITS);
            nsi4_in = nsi4_in <<< (2 * FRAC_BITS);
         end
         OP_DIVR: begin
            nsr4_in = NW'(ar3_ff);
            nsi4_in = NW'(ai3_ff);
            nsr4_in = nsr4_in <<< FRAC_BITS;
            nsi4_in = nsi4_in <<< FRAC_BITS;
         end
         default: begin
         end
      endcase

      // Split the products into a signed high half and an unsigned low half
      prh4_in = $signed(pr3_ff[2*W:W]);
      prl4_in = $signed({1'b0, pr3_ff[W-1:0]});
      pih4_in = $signed(pi3_ff[2*W:W]);
      pil4_in = $signed({1'b0, pi3_ff[W-1:0]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op4_ff    <= op3_ff;
         br4_ff    <= br3_ff;
         yr4_ff    <= sr4_in[W-1:0];
         yi4_ff    <= si4_in[W-1:0];
         ov4_ff    <= sr4_in[W] | si4_in[W];
         den4_ff   <= den3_ff;
         hprsr4_ff <= prh4_in * sr3_ff;
         lprsr4_ff <= prl4_in * sr3_ff;
         hpisi4_ff <= pih4_in * si3_ff;
         lpisi4_ff <= pil4_in * si3_ff;
         hpisr4_ff <= pih4_in * sr3_ff;
         lpisr4_ff <= pil4_in * sr3_ff;
         hprsi4_ff <= prh4_in * si3_ff;
         lprsi4_ff <= prl4_in * si3_ff;
         nsr4_ff   <= nsr4_in;
         nsi4_ff   <= nsi4_in;
      end
   end

   // Stage 5: assemble the parallel-combination dividends, pick dividends
   op_type                 op5_ff;
   logic signed [W-1:0]    br5_ff, yr5_ff, yi5_ff;
   logic                   ov5_ff;
   logic [DW-1:0]          den5_ff;
   logic signed [NW-1:0]   num_r5_ff, num_i5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         op5_ff  <= op4_ff;
         br5_ff  <= br4_ff;
         yr5_ff  <= yr4_ff;
         yi5_ff  <= yi4_ff;
         ov5_ff  <= ov4_ff;
         den5_ff <= den4_ff;
         if (op4_ff == OP_PAR) begin
            num_r5_ff <= join_pp(hprsr4_ff, lprsr4_ff) + join_pp(hpisi4_ff, lpisi4_ff);
            num_i5_ff <= join_pp(hpisr4_ff, lpisr4_ff) - join_pp(hprsi4_ff, lprsi4_ff);
         end else begin
            num_r5_ff <= nsr4_ff;
            num_i5_ff <= nsi4_ff;
         end
      end
   end

   // Stage 6: sign-magnitude dividends, divisor select, zero-divisor check
   fe_type                 fe6_ff;
   fe_type                 fe6_in;
   logic signed [NW-1:0]   mr6_in, mi6_in;
   logic [W-1:0]           abr6_in;

   always_comb begin
      fe6_in = '0;
      case (op5_ff) inside
         OP_DIV, OP_PAR, OP_DIVR, OP_RECIP: fe6_in.is_div = 1'b1;
         default:                           fe6_in.is_div = 1'b0;
      endcase
      abr6_in = br5_ff[W-1] ? (~br5_ff + W'(1)) : br5_ff;
      fe6_in.den = (op5_ff == OP_DIVR) ? DW'(abr6_in) : den5_ff;
      fe6_in.dz  = fe6_in.is_div && (fe6_in.den == '0);
      mr6_in = num_r5_ff[NW-1] ? -num_r5_ff : num_r5_ff;
      mi6_in = num_i5_ff[NW-1] ? -num_i5_ff : num_i5_ff;
      fe6_in.mag_r = mr6_in[MAG_WIDTH-1:0];
      fe6_in.mag_i = mi6_in[MAG_WIDTH-1:0];
      fe6_in.neg_r = num_r5_ff[NW-1] ^ ((op5_ff == OP_DIVR) && br5_ff[W-1]);
      fe6_in.neg_i = num_i5_ff[NW-1] ^ ((op5_ff == OP_DIVR) && br5_ff[W-1]);
      fe6_in.y_real = yr5_ff;
      fe6_in.y_imag = yi5_ff;
      fe6_in.ov     = ov5_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fe6_ff <= fe6_in;
      end
   end

   assign out_data = fe6_ff;

endmodule

FILE: src/cau_div.sv
// ---------------------------------------------------------------------------
// cau_div: pipelined restoring divider, two lanes sharing one divisor
// A range stage flags quotients that cannot fit, then one stage per
// quotient bit compares and subtracts the partial remainder.
// ---------------------------------------------------------------------------
module cau_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cau_pkg::fe_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output cau_pkg::dv_type  out_data
);
   import cau_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int DW = DEN_WIDTH;
   localparam int HW = MAG_WIDTH - DATA_WIDTH;
   localparam int CW = (HW > DW) ? HW : DW;

   // One quotient bit: shift in the next dividend bit, subtract if it fits
   function automatic logic [DW+W-1:0] step(input logic [DW-1:0] rem,
                                            input logic [W-1:0]  lq,
                                            input logic [DW-1:0] den);
      logic [DW:0] t;
      logic [DW:0] d;
      logic [DW-1:0] r;
      logic b;
      t = {rem, lq[W-1]};
      d = t - {1'b0, den};
      b = (t >= {1'b0, den});
      r = b ? d[DW-1:0] : t[DW-1:0];
      return {r, lq[W-2:0], b};
   endfunction

   logic [W:0]   v_ff;
   dv_type       st_ff [W+1];
   dv_type       st0_in;
   logic         en;
   logic [CW-1:0] hr0_in, hi0_in, dn0_in;

   // Advance all stages unless the last one holds a stalled request
   assign en        = !v_ff[W] || out_ready;
   assign in_ready  = en;
   assign out_valid = v_ff[W];
   assign out_data  = st_ff[W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[W-1:0], in_valid};
      end
   end

   // Range stage: a high dividend part at or above the divisor means overflow
   always_comb begin
      hr0_in = CW'(in_data.mag_r[MAG_WIDTH-1:W]);
      hi0_in = CW'(in_data.mag_i[MAG_WIDTH-1:W]);
      dn0_in = CW'(in_data.den);
      st0_in        = '0;
      st0_in.is_div = in_data.is_div;
      st0_in.dz     = in_data.dz;
      st0_in.neg_r  = in_data.neg_r;
      st0_in.neg_i  = in_data.neg_i;
      st0_in.big_r  = (hr0_in >= dn0_in);
      st0_in.big_i  = (hi0_in >= dn0_in);
      st0_in.rem_r  = hr0_in[DW-1:0];
      st0_in.rem_i  = hi0_in[DW-1:0];
      st0_in.den    = in_data.den;
      st0_in.lq_r   = in_data.mag_r[W-1:0];
      st0_in.lq_i   = in_data.mag_i[W-1:0];
      st0_in.y_real = in_data.y_real;
      st0_in.y_imag = in_data.y_imag;
      st0_in.ov     = in_data.ov;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= st0_in;
      end
   end

   // Quotient bit stages, most significant bit first
   for (genvar g = 1; g <= W; g++) begin : g_step
      dv_type st_in;

      always_comb begin
         st_in = st_ff[g-1];
         {st_in.rem_r, st_in.lq_r} = step(st_ff[g-1].rem_r, st_ff[g-1].lq_r, st_ff[g-1].den);
         {st_in.rem_i, st_in.lq_i} = step(st_ff[g-1].rem_i, st_ff[g-1].lq_i, st_ff[g-1].den);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[g] <= st_in;
         end
      end
   end

endmodule

FILE: src/cau_out.sv
// ---------------------------------------------------------------------------
// cau_out: result stage
// Signs and saturates the quotients, selects the result and flags, and
// holds the response in the output register.
// ---------------------------------------------------------------------------
module cau_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  cau_pkg::dv_type  in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_payload
);
   import cau_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] LIM = W'(1) << (W - 1);

   // Apply the sign to a quotient magnitude, saturating; top bit is overflow
   function automatic logic [W:0] sat_q(input logic neg, input logic big,
                                        input logic [W-1:0] q);
      logic [W:0] r;
      if (!neg) begin
         if (big || q[W-1]) r = {1'b1, ~LIM};
         else r = {1'b0, q};
      end else begin
         if (big || (q > LIM)) r = {1'b1, LIM};
         else r = {1'b0, ~q + 1'b1};
      end
      return r;
   endfunction

   logic    v_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic [W:0] qr_in, qi_in;

   assign in_ready    = !v_ff || rsp_ready;
   assign rsp_valid   = v_ff;
   assign rsp_payload = rsp_ff;

   // Pick quotient, zero-divisor or direct result
   always_comb begin
      qr_in = sat_q(in_data.neg_r, in_data.big_r, in_data.lq_r);
      qi_in = sat_q(in_data.neg_i, in_data.big_i, in_data.lq_i);
      rsp_in = '0;
      if (!in_data.is_div) begin
         rsp_in.y_real     = in_data.y_real;
         rsp_in.y_imag     = in_data.y_imag;
         rsp_in.overflowed = in_data.ov;
      end else if (in_data.dz) begin
         rsp_in.divide_by_zero = 1'b1;
      end else begin
         rsp_in.y_real     = qr_in[W-1:0];
         rsp_in.y_imag     = qi_in[W-1:0];
         rsp_in.overflowed = qr_in[W] | qi_in[W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: src/complex_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex ALU, signed fixed point
// Add, subtract, multiply, divide, parallel combination, scale, divide by
// real, negate, reciprocal and square, with saturation and zero-divisor flag.
//
//   channel  ports                          moves
//   req      req_valid/req_ready/req_payload  opcode and operands a, b
//   rsp      rsp_valid/rsp_ready/rsp_payload  result y and status flags
//
// One request enters per cycle unless a stalled response backs up to
// the input; every result passes 6 operand stages, 33 divider stages
// and one output register, the divider holding one stage per quotient bit.
// Reset clears only the valid bits; no clearing pass is needed.
// A stalled response freezes each block whose last stage is occupied,
// bubbles inside it included; a block with an empty last stage keeps
// advancing, so requests may still be taken while a result waits.
// ---------------------------------------------------------------------------
module complex_arithmetic_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cau_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_payload
);
   import cau_pkg::*;

   logic   fe_valid, fe_ready;
   fe_type fe_data;
   logic   dv_valid, dv_ready;
   dv_type dv_data;

   // Operand pipeline
   cau_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_payload),
      .out_valid (fe_valid),
      .out_ready (fe_ready),
      .out_data  (fe_data)
   );

   // Divider array
   cau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_data   (fe_data),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_data  (dv_data)
   );

   // Result stage
   cau_out u_out (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (dv_valid),
      .in_ready    (dv_ready),
      .in_data     (dv_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // A zero divisor gives a zero result and never reports saturation
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.divide_by_zero) |->
         (rsp_payload.y_real == '0 && rsp_payload.y_imag == '0 &&
          !rsp_payload.overflowed))
      else $error("zero-divisor response carries data or overflow");

   // A ready consumer lets the whole pipeline advance
   a_ready_through: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request stalled while the response side is ready");

   // No response is presented right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for complex_arithmetic_unit
// Drives opcode and operand requests with random gaps, stalls the response
// side at random, and checks every result against a wide-integer predictor
// of the fixed-point complex operations, in order.
// ---------------------------------------------------------------------------
module tb;
   import cau_pkg::*;

   localparam int FRAC_BITS   = 16;
   localparam int NUM_RANDOM  = 1250;
   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_WAIT  = 60;
   localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] VAL_ONE = 1 <<< FRAC_BITS;
   localparam logic [3:0] OP_UNDEF_FIRST = 4'd10;
   localparam logic [3:0] OP_UNDEF_LAST  = 4'd15;

   typedef logic signed [255:0] wide_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   logic    req_taken = 1'b0;
   int      req_gap = 0;
   int      rsp_gap = 0;
   bit      burst_mode = 1'b0;
   int      error_count = 0;
   int      checked_count = 0;
   int      dz_count = 0;
   int      sat_count = 0;
   int      idle_cycles = 0;

   complex_arithmetic_unit #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Clamp a wide value into the result range, noting saturation
   function automatic logic signed [DATA_WIDTH-1:0] clamp_part(wide_type v, inout logic ov);
      if (v > wide_type'(VAL_MAX)) begin
         ov = 1'b1;
         return VAL_MAX;
      end
      if (v < wide_type'(VAL_MIN)) begin
         ov = 1'b1;
         return VAL_MIN;
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   // Exact complex arithmetic, truncated toward zero, then saturated
   function automatic rsp_type complex_result(req_type r);
      wide_type ar, ai, br, bi, yr, yi, den, pr, pi, sr, si;
      wide_type scale;
      logic dz, ov;
      rsp_type res;
      ar = r.a_real; ai = r.a_imag; br = r.b_real; bi = r.b_imag;
      scale = wide_type'(1) <<< FRAC_BITS;
      yr = 0; yi = 0; dz = 1'b0; ov = 1'b0;
      case (r.opcode)
         OP_ADD: begin yr = ar + br; yi = ai + bi; end
         OP_SUB: begin yr = ar - br; yi = ai - bi; end
         OP_MUL: begin
            yr = (ar * br - ai * bi) / scale;
            yi = (ar * bi + ai * br) / scale;
         end
         OP_DIV: begin
            den = br * br + bi * bi;
            if (den == 0) dz = 1'b1;
            else begin
               yr = ((ar * br + ai * bi) * scale) / den;
               yi = ((ai * br - ar * bi) * scale) / den;
            end
         end
         OP_PAR: begin
            pr = ar * br - ai * bi;
            pi = ar * bi + ai * br;
            sr = ar + br;
            si = ai + bi;
            den = sr * sr + si * si;
            if (den == 0) dz = 1'b1;
            else begin
               yr = (pr * sr + pi * si) / den;
               yi = (pi * sr - pr * si) / den;
            end
         end
         OP_SCALE: begin yr = (ar * br) / scale; yi = (ai * br) / scale; end
         OP_DIVR: begin
            if (br == 0) dz = 1'b1;
            else begin
               yr = (ar * scale) / br;
               yi = (ai * scale) / br;
            end
         end
         OP_NEG: begin yr = -ar; yi = -ai; end
         OP_RECIP: begin
            den = ar * ar + ai * ai;
            if (den == 0) dz = 1'b1;
            else begin
               yr = (ar * scale * scale) / den;
               yi = (-ai * scale * scale) / den;
            end
         end
         OP_SQUARE: begin
            yr = (ar * ar - ai * ai) / scale;
            yi = (ar * ai + ai * ar) / scale;
         end
         default: ;
      endcase
      res.y_real = clamp_part(yr, ov);
      res.y_imag = clamp_part(yi, ov);
      res.divide_by_zero = dz;
      res.overflowed = ov;
      return res;
   endfunction

   function automatic void queue_request(logic [3:0] op, logic signed [DATA_WIDTH-1:0] ar,
                                         logic signed [DATA_WIDTH-1:0] ai,
                                         logic signed [DATA_WIDTH-1:0] br,
                                         logic signed [DATA_WIDTH-1:0] bi);
      req_type r;
      r.opcode = op; r.a_real = ar; r.a_imag = ai; r.b_real = br; r.b_imag = bi;
      pending_reqs.push_back(r);
   endfunction

   // Operand mix: extremes, zero, one, full random and moderate values
   function automatic logic signed [DATA_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 11))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return '0;
         3: return $urandom_range(0, 1) ? VAL_ONE : -VAL_ONE;
         4, 5, 6: return $urandom;
         default: return $signed($urandom_range(0, 2097152)) - 1048576;
      endcase
   endfunction

   function automatic logic [3:0] pick_opcode();
      if ($urandom_range(0, 29) == 0) return $urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST);
      return $urandom_range(OP_ADD, OP_SQUARE);
   endfunction

   // Mostly short gaps, a few long ones, none in burst stretches
   function automatic int pick_gap();
      if (burst_mode) return 0;
      case ($urandom_range(0, 19))
         0: return $urandom_range(10, 40);
         1, 2, 3, 4, 5: return $urandom_range(1, 3);
         default: return 0;
      endcase
   endfunction

   // Note each accepted request and predict its result
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         expected_rsps.push_back(complex_result(req_payload));
   end

   // Feed requests from the pending queue, hold until accepted
   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) burst_mode <= !burst_mode;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_taken) begin
         // hold the request until it is taken
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         req_payload <= pending_reqs.pop_front();
         req_valid <= 1'b1;
         req_gap <= pick_gap();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Stall the response side at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap <= pick_gap();
      end
   end

   // Compare each response with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_payload);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            checked_count++;
            if (want.divide_by_zero) dz_count++;
            if (want.overflowed) sat_count++;
            if (rsp_payload.y_real !== want.y_real)
               $display("%0t: y_real expected %h actual %h", $time,
                        want.y_real, rsp_payload.y_real);
            if (rsp_payload.y_imag !== want.y_imag)
               $display("%0t: y_imag expected %h actual %h", $time,
                        want.y_imag, rsp_payload.y_imag);
            if (rsp_payload.divide_by_zero !== want.divide_by_zero)
               $display("%0t: divide_by_zero expected %b actual %b", $time,
                        want.divide_by_zero, rsp_payload.divide_by_zero);
            if (rsp_payload.overflowed !== want.overflowed)
               $display("%0t: overflowed expected %b actual %b", $time,
                        want.overflowed, rsp_payload.overflowed);
            if (rsp_payload !== want) error_count++;
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type r;
      logic [3:0] op;
      // Directed: every opcode, extremes, zero divisors, undefined opcodes
      queue_request(OP_ADD, VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);
      queue_request(OP_SUB, VAL_MIN, VAL_MAX, VAL_MAX, VAL_MIN);
      queue_request(OP_MUL, VAL_ONE, -VAL_ONE, 3 * VAL_ONE, VAL_ONE / 2);
      queue_request(OP_MUL, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MAX);
      queue_request(OP_DIV, 5 * VAL_ONE, -VAL_ONE, VAL_ONE, 2 * VAL_ONE);
      queue_request(OP_DIV, VAL_ONE, VAL_ONE, '0, '0);
      queue_request(OP_DIV, VAL_MAX, VAL_MIN, 1, '0);
      queue_request(OP_PAR, 2 * VAL_ONE, VAL_ONE, VAL_ONE, -3 * VAL_ONE);
      queue_request(OP_PAR, VAL_ONE, -VAL_ONE, -VAL_ONE, VAL_ONE);
      queue_request(OP_PAR, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX);
      queue_request(OP_SCALE, VAL_MAX, VAL_MIN, VAL_MIN, VAL_MAX);
      queue_request(OP_SCALE, -3, 7, VAL_ONE / 2, '0);
      queue_request(OP_DIVR, VAL_ONE, -VAL_ONE, '0, VAL_ONE);
      queue_request(OP_DIVR, VAL_MIN, VAL_MAX, -1, VAL_MIN);
      queue_request(OP_DIVR, 7, -7, 2 * VAL_ONE, '0);
      queue_request(OP_NEG, VAL_MIN, VAL_MAX, '0, '0);
      queue_request(OP_RECIP, '0, '0, VAL_ONE, VAL_ONE);
      queue_request(OP_RECIP, 1, '0, '0, '0);
      queue_request(OP_RECIP, VAL_MAX, VAL_MIN, '0, '0);
      queue_request(OP_SQUARE, VAL_MIN, VAL_MIN, VAL_MAX, '0);
      queue_request(OP_SQUARE, -VAL_ONE, 2 * VAL_ONE, '0, '0);
      for (int i = OP_UNDEF_FIRST; i <= OP_UNDEF_LAST; i++)
         queue_request(4'(i), VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN);

      // Random requests with occasional forced zero divisors
      for (int i = 0; i < NUM_RANDOM; i++) begin
         op = pick_opcode();
         r.opcode = op;
         r.a_real = pick_operand(); r.a_imag = pick_operand();
         r.b_real = pick_operand(); r.b_imag = pick_operand();
         if ($urandom_range(0, 15) == 0) begin
            case (op)
               OP_DIV:   begin r.b_real = '0; r.b_imag = '0; end
               OP_PAR:   begin r.b_real = -r.a_real; r.b_imag = -r.a_imag; end
               OP_DIVR:  r.b_real = '0;
               OP_RECIP: begin r.a_real = '0; r.a_imag = '0; end
               default: ;
            endcase
         end
         queue_request(r.opcode, r.a_real, r.a_imag, r.b_real, r.b_imag);
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain everything, then let the pipeline settle
      wait (pending_reqs.size() == 0 && !req_valid);
      wait (expected_rsps.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Checked %0d results from directed and random opcodes, operand extremes",
               checked_count);
      $display("and stalls; %0d zero-divisor and %0d saturated results seen",
               dz_count, sat_count);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
